### rtl/otst_pkg.sv
package otst_pkg;

  // Operation codes on in_operation
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_CANCEL = 2'd2
  } otst_op_t;

  // Result kinds on out_result_kind
  typedef enum logic [1:0] {
    KIND_CREATED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_EXPIRED = 2'd3
  } otst_kind_t;

  // Field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned ACT_W   = 5;

  // Expiries reported per tick at most
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  // Controller to datapath commands
  typedef struct packed {
    logic load_op;      // capture operands of the accepted transaction
    logic new_timer;    // occupy slot at scan index
    logic free_slot;    // release slot at scan index
    logic upd_elapsed;  // write back the advanced elapsed count
    logic pend_create;  // stage a created result
    logic pend_full;    // stage a table-full result
    logic pend_cancel;  // stage a cancel result
    logic pend_expire;  // stage an expiry result
    logic push_pend;    // move staged result to output, not last
    logic flush_pend;   // move staged result to output as last
  } otst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy_at_idx;
    logic id_match;
    logic expire_hit;
    logic pend_valid;
    logic out_free;
    logic count_zero;
  } otst_stat_t;

endpackage

### rtl/otst_dp.sv
module otst_dp
  import otst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  otst_cmd_t                         cmd,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  input  logic [TIME_W-1:0]                 in_duration_ms,
  input  logic [ID_W-1:0]                   in_cancel_id,
  input  logic                              out_stall,
  output otst_stat_t                        stat,
  output logic                              out_valid,
  output logic [1:0]                        out_result_kind,
  output logic [ID_W-1:0]                   out_timer_id,
  output logic [SLOT_W-1:0]                 out_slot_index,
  output logic [ACT_W-1:0]                  out_active_count,
  output logic                              out_last
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Slot occupancy and counters
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [ID_W-1:0]   seq_r, seq_nxt;
  logic [ID_W-1:0]   seq_inc;

  // Captured operands
  logic [TIME_W-1:0] dur_r;
  logic [ID_W-1:0]   cid_r;

  // Slot memories
  logic [TIME_W-1:0] elapsed_mem  [SLOTS];
  logic [TIME_W-1:0] duration_mem [SLOTS];
  logic [ID_W-1:0]   id_mem       [SLOTS];
  logic [TIME_W-1:0] rd_el_r;
  logic [TIME_W-1:0] rd_dur_r;
  logic [ID_W-1:0]   rd_id_r;
  logic [TIME_W-1:0] el_inc;
  logic              elapsed_we;
  logic [TIME_W-1:0] elapsed_wd;

  // Staged result
  logic              pend_valid_r, pend_valid_nxt;
  otst_kind_t        pend_kind_r;
  logic [ID_W-1:0]   pend_id_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic [ACT_W-1:0]  pend_count_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  otst_kind_t        out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ACT_W-1:0]  out_count_r;
  logic              out_last_r;
  logic              out_free;

  // Saturating elapsed increment
  assign el_inc = (rd_el_r == {TIME_W{1'b1}}) ? rd_el_r : rd_el_r + TIME_W'(1);

  // Next id, skipping zero
  assign seq_inc = (seq_r + ID_W'(1) == '0) ? ID_W'(1) : seq_r + ID_W'(1);

  assign out_free = !out_valid_r || !out_stall;

  // Occupancy and id sequence next state
  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    seq_nxt   = seq_r;
    if (cmd.new_timer) begin
      busy_nxt[idx] = 1'b1;
      count_nxt     = count_r + CW'(1);
      seq_nxt       = seq_inc;
    end else if (cmd.free_slot) begin
      busy_nxt[idx] = 1'b0;
      count_nxt     = (count_r == '0) ? count_r : count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      count_r <= '0;
      seq_r   <= ID_W'(1);
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      seq_r   <= seq_nxt;
    end
  end

  // Operand capture
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      dur_r <= in_duration_ms;
      cid_r <= in_cancel_id;
    end
  end

  // Slot memories: one write at idx, one registered read at rd_addr
  assign elapsed_we = cmd.new_timer || cmd.upd_elapsed;
  assign elapsed_wd = cmd.new_timer ? '0 : el_inc;

  always_ff @(posedge clk) begin
    if (elapsed_we) begin
      elapsed_mem[idx] <= elapsed_wd;
    end
    if (cmd.new_timer) begin
      duration_mem[idx] <= dur_r;
      id_mem[idx]       <= seq_r;
    end
    rd_el_r  <= elapsed_mem[rd_addr];
    rd_dur_r <= duration_mem[rd_addr];
    rd_id_r  <= id_mem[rd_addr];
  end

  // Staged result register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.flush_pend) begin
      pend_valid_nxt = 1'b0;
    end
    if (cmd.pend_create || cmd.pend_full || cmd.pend_cancel || cmd.pend_expire) begin
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // At most one stage command per cycle; none leaves the payload as is
  always_ff @(posedge clk) begin
    if (cmd.pend_create) begin
      pend_kind_r  <= KIND_CREATED;
      pend_id_r    <= seq_r;
      pend_slot_r  <= SLOT_W'(idx);
      pend_count_r <= ACT_W'(count_r + CW'(1));
    end else if (cmd.pend_full) begin
      pend_kind_r  <= KIND_FULL;
      pend_id_r    <= '0;
      pend_slot_r  <= '0;
      pend_count_r <= ACT_W'(count_r);
    end else if (cmd.pend_cancel) begin
      pend_kind_r  <= KIND_CANCEL;
      pend_id_r    <= '0;
      pend_slot_r  <= '0;
      pend_count_r <= ACT_W'(count_r);
    end else if (cmd.pend_expire) begin
      pend_kind_r  <= KIND_EXPIRED;
      pend_id_r    <= rd_id_r;
      pend_slot_r  <= SLOT_W'(idx);
      pend_count_r <= ACT_W'(count_nxt);
    end
  end

  // Output register
  always_comb begin
    if (cmd.push_pend || cmd.flush_pend) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_pend || cmd.flush_pend) begin
      out_kind_r  <= pend_kind_r;
      out_id_r    <= pend_id_r;
      out_slot_r  <= pend_slot_r;
      out_count_r <= pend_count_r;
      out_last_r  <= cmd.flush_pend;
    end
  end

  // Status to controller
  assign stat.busy_at_idx = busy_r[idx];
  assign stat.id_match    = busy_r[idx] && (rd_id_r == cid_r) && (cid_r != '0);
  assign stat.expire_hit  = busy_r[idx] && (el_inc >= rd_dur_r);
  assign stat.pend_valid  = pend_valid_r;
  assign stat.out_free    = out_free;
  assign stat.count_zero  = (count_r == '0);

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_timer_id     = out_id_r;
  assign out_slot_index   = out_slot_r;
  assign out_active_count = out_count_r;
  assign out_last         = out_last_r;

endmodule

### rtl/otst_ctrl.sv
module otst_ctrl
  import otst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [1:0]                        in_operation,
  output logic                              in_stall,
  input  otst_stat_t                        stat,
  output otst_cmd_t                         cmd,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] idx,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_CREATE     = 6'b000010,
    S_CANCEL     = 6'b000100,
    S_CANCEL_END = 6'b001000,
    S_TICK       = 6'b010000,
    S_FLUSH      = 6'b100000
  } otst_state_t;

  otst_state_t       state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;
  logic [IW-1:0]     idx_next_slot;
  logic              at_last;
  logic              hit;

  assign at_last       = (idx_r == LAST_IDX);
  assign idx_next_slot = at_last ? '0 : idx_r + IW'(1);
  assign hit           = stat.expire_hit && (n_r < NRES_W'(MAX_RESULTS));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    cmd       = '0;
    rd_addr   = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          idx_nxt     = '0;
          n_nxt       = '0;
          if (in_operation == OP_CREATE) begin
            state_nxt = S_CREATE;
          end else if (in_operation == OP_CANCEL) begin
            state_nxt = S_CANCEL;
          end else if (in_operation == OP_TICK && !stat.count_zero) begin
            state_nxt = S_TICK;
          end
        end
      end
      S_CREATE: begin
        // first free slot wins
        if (!stat.busy_at_idx) begin
          cmd.new_timer   = 1'b1;
          cmd.pend_create = 1'b1;
          state_nxt       = S_FLUSH;
        end else if (at_last) begin
          cmd.pend_full = 1'b1;
          state_nxt     = S_FLUSH;
        end else begin
          idx_nxt = idx_next_slot;
        end
      end
      S_CANCEL: begin
        rd_addr = idx_next_slot;
        if (stat.id_match) begin
          cmd.free_slot = 1'b1;
        end
        if (at_last) begin
          state_nxt = S_CANCEL_END;
        end else begin
          idx_nxt = idx_next_slot;
        end
      end
      S_CANCEL_END: begin
        cmd.pend_cancel = 1'b1;
        state_nxt       = S_FLUSH;
      end
      S_TICK: begin
        // hold while a second expiry has nowhere to go
        if (hit && stat.pend_valid && !stat.out_free) begin
          rd_addr = idx_r;
        end else begin
          rd_addr = idx_next_slot;
          if (stat.busy_at_idx) begin
            if (hit) begin
              cmd.free_slot   = 1'b1;
              cmd.pend_expire = 1'b1;
              cmd.push_pend   = stat.pend_valid;
              n_nxt           = n_r + NRES_W'(1);
            end else begin
              cmd.upd_elapsed = 1'b1;
            end
          end
          if (at_last) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt = idx_next_slot;
          end
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush_pend = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

  assign idx = idx_r;

endmodule

### rtl/one_shot_timer_table_top.sv
// One-shot millisecond timer table.
// Input channel (in_valid/in_stall): one transaction per operation: tick,
// create (in_duration_ms) or cancel (in_cancel_id). Codes outside the set
// are dropped without a result.
// Result channel (out_valid/out_stall): create and cancel give one result;
// a tick gives one expiry result per expired slot, in slot order, up to 16.
// out_last marks the final result of a transaction.
// Timing: the block takes one transaction at a time. A create walks the
// busy bits from slot 0 until it finds a free slot or reaches the last;
// a cancel and a tick walk every slot in order, one slot at a time,
// through the single read/write port of the slot memories. A tick with
// no active timer stays in idle. The last result shows on out_valid at
// the edge the block goes back to idle.
// Results leave through an output register plus one
// staging register, so the scan keeps going while one result waits.
// Stalls: if both registers are full when another slot expires, the scan
// holds on that slot until out_stall drops; payloads hold while stalled.
// Reset: all slots free, active count zero, next id 1. No clearing pass.
module one_shot_timer_table_top
  import otst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_duration_ms,
  input  logic [ID_W-1:0]   in_cancel_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_result_kind,
  output logic [ID_W-1:0]   out_timer_id,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [ACT_W-1:0]  out_active_count,
  output logic              out_last
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  otst_cmd_t     cmd;
  otst_stat_t    stat;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_addr;

  otst_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd),
    .idx          (idx),
    .rd_addr      (rd_addr)
  );

  otst_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .idx              (idx),
    .rd_addr          (rd_addr),
    .in_duration_ms   (in_duration_ms),
    .in_cancel_id     (in_cancel_id),
    .out_stall        (out_stall),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_timer_id     (out_timer_id),
    .out_slot_index   (out_slot_index),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  // A created timer never gets id zero
  a_created_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_CREATED) |-> (out_timer_id != '0))
    else $error("created timer carries id zero");

  // Table-full result only when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_FULL) |->
      (out_active_count == ACT_W'(SLOTS) && out_timer_id == '0))
    else $error("table-full result with free slots");

  // Create and cancel each give a single, final result
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_CREATED || out_result_kind == KIND_FULL ||
                   out_result_kind == KIND_CANCEL)) |-> out_last)
    else $error("create or cancel result not marked last");

  // A create transaction keeps the input side busy on the next cycle
  a_create_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_operation == OP_CREATE) |=> in_stall)
    else $error("input taken while a create is in progress");

  // The memory commands never free and occupy a slot together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.new_timer && cmd.free_slot))
    else $error("slot occupied and freed in the same cycle");

endmodule

### bench/timer_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the timer table, keeps its own copy of the slot
// state, and compares every result transaction against the oldest prediction.
module timer_table_checker
  import otst_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [TIME_W-1:0] in_duration_ms,
  input  logic [ID_W-1:0]   in_cancel_id,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_result_kind,
  input  logic [ID_W-1:0]   out_timer_id,
  input  logic [SLOT_W-1:0] out_slot_index,
  input  logic [ACT_W-1:0]  out_active_count,
  input  logic              out_last,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   timer_id;
    logic [SLOT_W-1:0] slot;
    logic [ACT_W-1:0]  active;
    logic              last;
  } timer_result_t;

  // Results still owed by the block, oldest first
  timer_result_t awaited_results[$];

  // Shadow copy of the timer table
  bit              slot_used  [SLOTS];
  bit [TIME_W-1:0] slot_age   [SLOTS];
  bit [TIME_W-1:0] slot_limit [SLOTS];
  bit [ID_W-1:0]   slot_owner [SLOTS];
  bit [ACT_W-1:0]  used_count;
  bit [ID_W-1:0]   next_id;
  int unsigned     errors;

  initial begin
    errors = 0;
    mismatch_count = 0;
    pending_count = 0;
  end

  function automatic void clear_table();
    for (int unsigned s = 0; s < SLOTS; s++) begin
      slot_used[s]  = 1'b0;
      slot_age[s]   = '0;
      slot_limit[s] = '0;
      slot_owner[s] = '0;
    end
    used_count = '0;
    next_id = 1;
  endfunction

  function automatic void release_slot(input int unsigned s);
    slot_used[s]  = 1'b0;
    slot_age[s]   = '0;
    slot_limit[s] = '0;
    slot_owner[s] = '0;
    if (used_count != 0)
      used_count--;
  endfunction

  // Active count is taken after the state change that caused the result
  function automatic void owe_result(input otst_kind_t kind, input logic [ID_W-1:0] id,
                                     input int unsigned slot, input logic last);
    timer_result_t r;
    r.kind     = kind;
    r.timer_id = id;
    r.slot     = slot[SLOT_W-1:0];
    r.active   = used_count;
    r.last     = last;
    awaited_results.push_back(r);
  endfunction

  // Apply one accepted transaction to the shadow table
  function automatic void advance_timer_table(input logic [1:0] op,
                                              input logic [TIME_W-1:0] dur,
                                              input logic [ID_W-1:0] cid);
    bit placed;
    int unsigned fired;
    logic [ID_W-1:0] id;
    timer_result_t tail;
    placed = 1'b0;
    fired = 0;
    case (op)
      OP_CREATE: begin
        // lowest free slot wins
        for (int unsigned s = 0; s < SLOTS && !placed; s++) begin
          if (!slot_used[s]) begin
            slot_used[s]  = 1'b1;
            slot_age[s]   = '0;
            slot_limit[s] = dur;
            slot_owner[s] = next_id;
            used_count++;
            owe_result(KIND_CREATED, next_id, s, 1'b1);
            next_id++;
            if (next_id == 0)
              next_id = 1;
            placed = 1'b1;
          end
        end
        if (!placed)
          owe_result(KIND_FULL, '0, 0, 1'b1);
      end
      OP_CANCEL: begin
        if (cid != 0) begin
          for (int unsigned s = 0; s < SLOTS; s++)
            if (slot_used[s] && slot_owner[s] == cid)
              release_slot(s);
        end
        owe_result(KIND_CANCEL, '0, 0, 1'b1);
      end
      OP_TICK: begin
        // empty table: nothing moves
        if (used_count != 0) begin
          for (int unsigned s = 0; s < SLOTS; s++) begin
            if (slot_used[s]) begin
              if (slot_age[s] != '1)
                slot_age[s]++;
              if (slot_age[s] >= slot_limit[s] && fired < MAX_RESULTS) begin
                id = slot_owner[s];
                release_slot(s);
                owe_result(KIND_EXPIRED, id, s, 1'b0);
                fired++;
              end
            end
          end
          if (fired > 0) begin
            tail = awaited_results.pop_back();
            tail.last = 1'b1;
            awaited_results.push_back(tail);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      clear_table();
      awaited_results.delete();
    end else begin
      // input first: a result never leaves on the edge that took its cause
      if (in_valid && !in_stall)
        advance_timer_table(in_operation, in_duration_ms, in_cancel_id);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t unexpected result: kind %0d id %h slot %0d active %0d last %b",
                     $realtime, out_result_kind, out_timer_id, out_slot_index,
                     out_active_count, out_last);
        end else begin
          want = awaited_results.pop_front();
          if (out_result_kind !== want.kind || out_timer_id !== want.timer_id ||
              out_slot_index !== want.slot || out_active_count !== want.active ||
              out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"%t result mismatch: expected kind %0d id %h slot %0d active %0d",
                        " last %b, got kind %0d id %h slot %0d active %0d last %b"},
                       $realtime, want.kind, want.timer_id, want.slot, want.active,
                       want.last, out_result_kind, out_timer_id, out_slot_index,
                       out_active_count, out_last);
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_count <= awaited_results.size();
  end

endmodule

### bench/one_shot_timer_table_top_tb.sv
`timescale 1ns / 1ps

module one_shot_timer_table_top_tb;
  import otst_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned RANDOM_ITEMS = 230;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS;
  localparam int unsigned HOLD_AT_ITEM = 70;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = OP_TICK;
  logic [TIME_W-1:0] in_duration_ms = '0;
  logic [ID_W-1:0]   in_cancel_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_result_kind;
  logic [ID_W-1:0]   out_timer_id;
  logic [SLOT_W-1:0] out_slot_index;
  logic [ACT_W-1:0]  out_active_count;
  logic              out_last;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned idle_cycles = 0;
  int unsigned creates_sent = 0;
  bit          hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  one_shot_timer_table_top #(.SLOTS(SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_duration_ms   (in_duration_ms),
    .in_cancel_id     (in_cancel_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_timer_id     (out_timer_id),
    .out_slot_index   (out_slot_index),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  timer_table_checker #(.SLOTS(SLOTS)) u_timer_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_duration_ms   (in_duration_ms),
    .in_cancel_id     (in_cancel_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_timer_id     (out_timer_id),
    .out_slot_index   (out_slot_index),
    .out_active_count (out_active_count),
    .out_last         (out_last),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  // Offer one transaction and hold it until the block takes it
  task automatic offer_op(input logic [1:0] op, input logic [TIME_W-1:0] dur,
                          input logic [ID_W-1:0] cid);
    in_valid <= 1'b1;
    in_operation <= op;
    in_duration_ms <= dur;
    in_cancel_id <= cid;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (op == OP_CREATE)
      creates_sent++;
  endtask

  // Mostly back to back, sometimes a short pause, rarely a long one
  task automatic sender_pause();
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      span = 0;
    else if (pick < 88)
      span = $urandom_range(1, 3);
    else
      span = $urandom_range(8, 40);
    if (span > 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // An id handed out recently, or one just about to be
  function automatic logic [ID_W-1:0] recent_id();
    int unsigned hi;
    int unsigned lo;
    hi = creates_sent + 1;
    lo = (hi > 24) ? hi - 24 : 1;
    return $urandom_range(hi, lo);
  endfunction

  // Stimulus
  initial begin : stimulus
    int unsigned done_items;
    int unsigned pick;
    logic [TIME_W-1:0] dur;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // tick on an empty table, then an unused code
    offer_op(OP_TICK, $urandom, $urandom);
    sender_pause();
    offer_op(OP_UNUSED, '1, '1);
    sender_pause();
    // zero duration fires on the next tick
    offer_op(OP_CREATE, '0, $urandom);
    sender_pause();
    offer_op(OP_TICK, $urandom, $urandom);
    sender_pause();
    offer_op(OP_CANCEL, $urandom, '0);
    sender_pause();
    // fill every slot, two of them with huge durations
    for (int unsigned k = 0; k < SLOTS; k++) begin
      if (k == 0)
        dur = '1;
      else if (k == 1)
        dur = 32'h8000_0000;
      else
        dur = k % 3;
      offer_op(OP_CREATE, dur, $urandom);
      sender_pause();
    end
    offer_op(OP_CREATE, 32'd5, $urandom);
    sender_pause();
    offer_op(OP_CANCEL, $urandom, '1);
    sender_pause();
    offer_op(OP_CANCEL, $urandom, 32'd2);
    sender_pause();
    offer_op(OP_CANCEL, $urandom, 32'd3);
    sender_pause();
    // several expiries on one tick
    offer_op(OP_TICK, $urandom, $urandom);
    sender_pause();
    offer_op(OP_TICK, $urandom, $urandom);
    sender_pause();

    // Random mix: mostly short timers that expire, cancels of live ids
    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      if (done_items == HOLD_AT_ITEM && !hold_request)
        hold_request <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45)
        offer_op(OP_TICK, $urandom, $urandom);
      else if (pick < 75)
        offer_op(OP_CREATE, $urandom_range(0, 12), $urandom);
      else if (pick < 79)
        offer_op(OP_CREATE, $urandom, $urandom);
      else if (pick < 93)
        offer_op(OP_CANCEL, $urandom, recent_id());
      else if (pick < 97)
        offer_op(OP_CANCEL, $urandom, ($urandom_range(0, 1) != 0) ? $urandom : 0);
      else
        offer_op(OP_UNUSED, $urandom, $urandom);
      if (pick < 97)
        done_items++;
      sender_pause();
    end
    in_valid <= 1'b0;

    // drain, then give a trailing tick scan time to finish
    do
      @(posedge clk);
    while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Result side stall: calm stretches, random stalls, long holds
  initial begin : result_stall
    bit          held;
    int unsigned pick;
    int unsigned span;
    int unsigned odds;
    held = 1'b0;
    while (!rst_n)
      @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        // long hold-off so the block backs up into its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 9) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          span = $urandom_range(5, 60);
          odds = (pick < 3) ? 0 : $urandom_range(10, 60);
          repeat (span) begin
            out_stall <= ($urandom_range(0, 99) < odds);
            @(posedge clk);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

### files.f
rtl/otst_pkg.sv
rtl/otst_dp.sv
rtl/otst_ctrl.sv
rtl/one_shot_timer_table_top.sv
bench/timer_table_checker.sv
bench/one_shot_timer_table_top_tb.sv
